// ===== rtl/prsc_pkg.sv =====
// Shared types, constants and functions for the printable rotation stream cipher.
// No dependencies; used by every other file of the block.
package prsc_pkg;

  localparam int unsigned GenW  = 17;
  localparam int unsigned SeedW = 16;
  localparam int unsigned ByteW = 8;
  localparam int unsigned SpanW = 7;

  localparam logic [GenW-1:0]  LehmerMult = 17'd75;
  localparam logic [GenW:0]    LehmerMod  = 18'd65537;
  localparam logic [ByteW-1:0] PrintLo    = 8'd32;
  localparam logic [ByteW-1:0] Span       = 8'd96;
  localparam logic [GenW-1:0]  GenReset   = 17'd1;
  localparam logic [SeedW-1:0] SeedReset  = 16'd1;

  typedef enum logic [0:0] {
    CFG_SEED = 1'b0,
    CFG_MODE = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic load;
    logic restart;
  } gen_ctl_t;

  // value * 75 mod 65537, folded: low half minus high part, add modulus on borrow
  function automatic logic [GenW-1:0] lehmer_step(input logic [GenW-1:0] v);
    logic [23:0] prod;
    logic [15:0] lo;
    logic [7:0]  hi;
    logic [GenW:0] sum;
    prod = {7'd0, v} * {7'd0, LehmerMult};
    lo   = prod[15:0];
    hi   = prod[23:16];
    if ({8'd0, lo} >= {16'd0, hi}) begin
      sum = {2'd0, lo} - {10'd0, hi};
    end else begin
      sum = {2'd0, lo} + LehmerMod - {10'd0, hi};
    end
    return sum[GenW-1:0];
  endfunction

  // r mod 96 = ((r >> 5) mod 3) * 32 + r[4:0]; base-4 digit sum for mod 3
  function automatic logic [SpanW-1:0] mod_span(input logic [GenW-1:0] r);
    logic [4:0] dsum;
    logic [2:0] fold;
    logic [1:0] m3;
    dsum = {3'd0, r[6:5]} + {3'd0, r[8:7]} + {3'd0, r[10:9]}
         + {3'd0, r[12:11]} + {3'd0, r[14:13]} + {3'd0, r[16:15]};
    fold = {1'b0, dsum[1:0]} + {1'b0, dsum[3:2]} + {2'd0, dsum[4]};
    if (fold >= 3'd6) begin
      m3 = 2'(fold - 3'd6);
    end else if (fold >= 3'd3) begin
      m3 = 2'(fold - 3'd3);
    end else begin
      m3 = fold[1:0];
    end
    return {m3, r[4:0]};
  endfunction

endpackage

// ===== rtl/printable_rotation_stream_cipher.sv =====
// Top level of the printable rotation stream cipher.
// Depends on prsc_pkg, prsc_keygen and prsc_rotate.
//
// Input channel: in_valid, in_stall, in_data_byte, in_start_of_stream. A word is
// taken at a clock edge with in_valid high and in_stall low. A set start flag
// reloads the generator from the seed register before that word is coded.
// Result channel: out_valid, out_stall, out_coded_byte; one result per input word.
// Bytes 32..127 are rotated within that range by the key mod 96; all others pass.
// Configuration: cfg_wr_en, cfg_index (0 seed, 1 decrypt mode), cfg_wr_data;
// write only while no word is in flight.
// Pipeline: generator step and input word are registered at the accept; the mod-96
// rotation is registered into the result register when the pipeline advances again.
// Throughput: one word per cycle unless stalled, set by the generator feedback loop.
// Reset: synchronous, active low; seed 1, encrypt mode, generator 1, pipeline empty.
// Stall: while a result is held and out_stall is high, the whole pipeline holds
// and in_stall is raised; a free result register lets words flow on.
module printable_rotation_stream_cipher (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [0:0]                    cfg_index,
  input  logic [prsc_pkg::SeedW-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [prsc_pkg::ByteW-1:0]    in_data_byte,
  input  logic                          in_start_of_stream,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [prsc_pkg::ByteW-1:0]    out_coded_byte
);

  logic [prsc_pkg::SeedW-1:0] seed_r;
  logic [prsc_pkg::SeedW-1:0] seed_nxt;
  logic                       decrypt_r;
  logic                       decrypt_nxt;
  logic                       stg_valid_r;
  logic                       stg_valid_nxt;
  logic [prsc_pkg::ByteW-1:0] stg_byte_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic                       advance;
  logic                       accept;
  logic [prsc_pkg::GenW-1:0]  key;
  prsc_pkg::gen_ctl_t         gen_ctl;

  always_comb begin
    seed_nxt    = seed_r;
    decrypt_nxt = decrypt_r;
    if (cfg_wr_en) begin
      unique case (prsc_pkg::cfg_idx_t'(cfg_index))
        prsc_pkg::CFG_SEED: seed_nxt    = cfg_wr_data;
        prsc_pkg::CFG_MODE: decrypt_nxt = cfg_wr_data[0];
      endcase
    end
  end

  always_comb begin
    advance         = !out_valid_r || !out_stall;
    accept          = in_valid && advance;
    gen_ctl.load    = accept;
    gen_ctl.restart = in_start_of_stream;
    stg_valid_nxt   = advance ? in_valid : stg_valid_r;
    out_valid_nxt   = advance ? stg_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r      <= prsc_pkg::SeedReset;
      decrypt_r   <= 1'b0;
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seed_r      <= seed_nxt;
      decrypt_r   <= decrypt_nxt;
      stg_valid_r <= stg_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stg_byte_r <= in_data_byte;
    end
  end

  prsc_keygen u_keygen (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (gen_ctl),
    .seed      (seed_r),
    .gen_value (key)
  );

  prsc_rotate u_rotate (
    .clk      (clk),
    .en       (advance),
    .data     (stg_byte_r),
    .key      (key),
    .backward (decrypt_r),
    .coded    (out_coded_byte)
  );

  assign in_stall  = !advance;
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/prsc_keygen.sv =====
// Lehmer keystream generator: one step per accepted word, from the seed on restart.
// Depends on prsc_pkg.
module prsc_keygen (
  input  logic                          clk,
  input  logic                          rst_n,
  input  prsc_pkg::gen_ctl_t            ctl,
  input  logic [prsc_pkg::SeedW-1:0]    seed,
  output logic [prsc_pkg::GenW-1:0]     gen_value
);

  logic [prsc_pkg::GenW-1:0] gen_r;
  logic [prsc_pkg::GenW-1:0] gen_nxt;
  logic [prsc_pkg::GenW-1:0] gen_base;

  always_comb begin
    gen_base = ctl.restart ? {1'b0, seed} : gen_r;
    gen_nxt  = ctl.load ? prsc_pkg::lehmer_step(gen_base) : gen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r <= prsc_pkg::GenReset;
    end else begin
      gen_r <= gen_nxt;
    end
  end

  assign gen_value = gen_r;

endmodule

// ===== rtl/prsc_rotate.sv =====
// Rotation of a printable byte by the key mod 96, into the result register.
// Depends on prsc_pkg.
module prsc_rotate (
  input  logic                          clk,
  input  logic                          en,
  input  logic [prsc_pkg::ByteW-1:0]    data,
  input  logic [prsc_pkg::GenW-1:0]     key,
  input  logic                          backward,
  output logic [prsc_pkg::ByteW-1:0]    coded
);

  logic [prsc_pkg::ByteW-1:0]  coded_r;
  logic [prsc_pkg::ByteW-1:0]  coded_nxt;
  logic [prsc_pkg::SpanW-1:0]  shift;
  logic [prsc_pkg::ByteW-1:0]  offs;
  logic [prsc_pkg::ByteW-1:0]  sum;
  logic [prsc_pkg::ByteW-1:0]  wrapped;
  logic                        printable;

  always_comb begin
    printable = !data[7] && (data[6:5] != 2'b00);
    shift     = prsc_pkg::mod_span(key);
    offs      = data - prsc_pkg::PrintLo;
    if (backward) begin
      sum = offs + prsc_pkg::Span - {1'b0, shift};
    end else begin
      sum = offs + {1'b0, shift};
    end
    wrapped   = (sum >= prsc_pkg::Span) ? sum - prsc_pkg::Span : sum;
    coded_nxt = printable ? wrapped + prsc_pkg::PrintLo : data;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      coded_r <= coded_nxt;
    end
  end

  assign coded = coded_r;

endmodule

// ===== rtl/prsc_checker.sv =====
// Port-level checks for the printable rotation stream cipher, bound to the top level.
// Depends on printable_rotation_stream_cipher and prsc_pkg.
module prsc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [prsc_pkg::ByteW-1:0]    out_coded_byte
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_coded_byte))
    else $error("result word changed while stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind printable_rotation_stream_cipher prsc_checker u_prsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_coded_byte (out_coded_byte)
);
